>>> design/e2rm_pkg.sv
// ----------------------------------------------------------------------------
// e2rm_pkg
// Shared constants and arithmetic helpers for the Euler-to-rotation-matrix
// pipeline: CORDIC arctangent table, reduction constants, Q30 product.
// ----------------------------------------------------------------------------
`default_nettype none

package e2rm_pkg;

  // Field widths fixed by the stream format
  localparam int unsigned AngleW = 24;
  localparam int unsigned EntryW = 16;

  // CORDIC datapath widths (x/y carry 30 fraction bits, z 24 fraction bits)
  localparam int unsigned XyW = 33;
  localparam int unsigned ZW  = 34;

  // Gain-compensated starting x, 0.60725293 in Q30
  localparam logic signed [XyW-1:0] GainInit = 33'sd652032874;

  // Offset that makes any integer-degree value non-negative, a multiple of 360
  localparam logic signed [25:0] ModOffset = 26'sd8388720;
  // floor(2^32 / 360) for the reciprocal estimate of the quotient
  localparam logic [23:0] Recip360 = 24'd11930464;
  localparam logic [8:0]  Deg360   = 9'd360;

  // atan(2^-i) in degrees, 24 fraction bits
  localparam logic signed [ZW-1:0] AtanQ24 [32] = '{
    34'sd754974720, 34'sd445687602, 34'sd235489088, 34'sd119537938,
    34'sd60000934,  34'sd30029717,  34'sd15018523,  34'sd7509720,
    34'sd3754917,   34'sd1877466,   34'sd938734,    34'sd469367,
    34'sd234684,    34'sd117342,    34'sd58671,     34'sd29335,
    34'sd14668,     34'sd7334,      34'sd3667,      34'sd1833,
    34'sd917,       34'sd458,       34'sd229,       34'sd115,
    34'sd57,        34'sd29,        34'sd14,        34'sd7,
    34'sd4,         34'sd2,         34'sd1,         34'sd0
  };

  // Q30 product, rounded half up
  function automatic logic signed [XyW-1:0] qmul(input logic signed [XyW-1:0] a,
                                                 input logic signed [XyW-1:0] b);
    logic signed [2*XyW-1:0] p;
    p = a * b + (66'sd1 <<< 29);
    return p[62:30];
  endfunction

endpackage

`default_nettype wire

>>> design/euler_to_rotation_matrix.sv
// ----------------------------------------------------------------------------
// euler_to_rotation_matrix
// Converts X/Y/Z Euler angles (degrees) to the 3x3 rotation matrix in Q1.14
// through angle reduction, three CORDIC lanes and two product stages.
// ----------------------------------------------------------------------------
//  channel  | dir | payload
//  ---------+-----+-----------------------------------------------------------
//  s_axis   | in  | tdata[71:0]: angle_x, angle_y, angle_z (24b signed each)
//  m_axis   | out | tdata[143:0]: m00..m22 row-major (16b signed each)
//
//  The pipeline has two reduction stages, one CORDIC stage per iteration,
//  two product stages and the output register. One request per cycle is
//  sustained unless the output stalls; the pipeline carries one item per stage.
//  A stalled output freezes every stage together; nothing is lost or repeated.
//  Reset clears the valid bits only.
`default_nettype none

module euler_to_rotation_matrix #(
  parameter int unsigned ANGLE_FRAC_BITS = 8,
  parameter int unsigned OUT_FRAC_BITS   = 14,
  parameter int unsigned TRIG_ITERATIONS = 16
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          s_axis_tvalid,
  output logic               s_axis_tready,
  input  wire logic [71:0]   s_axis_tdata,  // angle_x, angle_y, angle_z
  output logic               m_axis_tvalid,
  input  wire logic          m_axis_tready,
  output logic [143:0]       m_axis_tdata   // m00,m01,m02,m10,m11,m12,m20,m21,m22
);
  import e2rm_pkg::*;

  localparam int unsigned N     = TRIG_ITERATIONS;
  localparam int unsigned Depth = N + 5;
  localparam int unsigned Sh    = 30 - OUT_FRAC_BITS;

  localparam logic [AngleW-1:0] LowMask = AngleW'((25'd1 << ANGLE_FRAC_BITS) - 25'd1);
  localparam logic signed [ZW-1:0] Period  = ZW'(360) <<< ANGLE_FRAC_BITS;
  localparam logic signed [ZW-1:0] Half    = ZW'(180) <<< ANGLE_FRAC_BITS;
  localparam logic signed [ZW-1:0] Quarter = ZW'(90)  <<< ANGLE_FRAC_BITS;
  localparam logic signed [ZW-1:0] ZLimit  = ZW'(90)  <<< 24;

  localparam logic signed [35:0] Rnd  = (Sh > 0) ? (36'sd1 <<< (Sh - 1)) : 36'sd0;
  localparam logic signed [35:0] One  = 36'sd1 <<< OUT_FRAC_BITS;
  localparam logic signed [35:0] SMax = 36'sd32767;
  localparam logic signed [35:0] SMin = -36'sd32768;

  // Round to the output format and saturate
  function automatic logic [EntryW-1:0] to_out(input logic signed [ZW-1:0] v);
    logic signed [35:0] q;
    q = (36'(v) + Rnd) >>> Sh;
    if (q > One)  q = One;
    if (q < -One) q = -One;
    if (q > SMax) q = SMax;
    if (q < SMin) q = SMin;
    return q[EntryW-1:0];
  endfunction

  logic             en;
  logic [Depth-1:0] vld_q;

  // Advance all stages unless the output holds an untaken result
  assign en            = !vld_q[Depth-1] || m_axis_tready;
  assign s_axis_tready = en;
  assign m_axis_tvalid = vld_q[Depth-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[Depth-2:0], s_axis_tvalid};
    end
  end

  // Reduction and CORDIC registers, one set per lane
  logic [24:0]             u_q   [3];
  logic [16:0]             est_q [3];
  logic [AngleW-1:0]       low_q [3];
  logic signed [XyW-1:0]   x_q   [N+1][3];
  logic signed [XyW-1:0]   y_q   [N+1][3];
  logic signed [ZW-1:0]    z_q   [N][3];
  logic                    flip_q[N][3];

  for (genvar l = 0; l < 3; l++) begin : g_lane
    logic signed [AngleW-1:0] ang;
    logic signed [AngleW-1:0] qdeg;
    logic signed [25:0]       us;
    logic [48:0]              prod;

    // Stage 1: integer degrees, offset, quotient estimate by reciprocal
    assign ang  = $signed(s_axis_tdata[AngleW*l +: AngleW]);
    assign qdeg = ang >>> ANGLE_FRAC_BITS;
    assign us   = 26'(qdeg) + ModOffset;
    assign prod = 49'(us[24:0]) * 49'(Recip360);

    always_ff @(posedge clk_i) begin
      if (en) begin
        u_q[l]   <= us[24:0];
        est_q[l] <= prod[48:32];
        low_q[l] <= ang & LowMask;
      end
    end

    // Stage 2: remainder, fold to [-90, 90], CORDIC seed
    logic signed [26:0]   rem0, rem;
    logic signed [ZW-1:0] r0, r1, r;
    logic                 flip;
    logic [25:0]          est360;

    always_comb begin
      est360 = 26'(est_q[l]) * 26'(Deg360);
      rem0   = $signed({2'b00, u_q[l]}) - $signed({1'b0, est360});
      rem    = (rem0 >= 27'sd360) ? rem0 - 27'sd360 : rem0;
      r0     = (ZW'(rem) <<< ANGLE_FRAC_BITS) + $signed({10'b0, low_q[l]});
      r1     = (r0 >= Half) ? r0 - Period : r0;
      flip   = 1'b0;
      r      = r1;
      if (r1 > Quarter) begin
        r    = r1 - Half;
        flip = 1'b1;
      end else if (r1 < -Quarter) begin
        r    = r1 + Half;
        flip = 1'b1;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        x_q[0][l]    <= GainInit;
        y_q[0][l]    <= '0;
        z_q[0][l]    <= r <<< (24 - ANGLE_FRAC_BITS);
        flip_q[0][l] <= flip;
      end
    end

    // CORDIC: one micro-rotation per stage, sign applied at the last
    for (genvar k = 0; k < N; k++) begin : g_iter
      logic signed [XyW-1:0] dx, dy, xn, yn;
      logic                  pos;

      always_comb begin
        dx  = y_q[k][l] >>> k;
        dy  = x_q[k][l] >>> k;
        pos = (z_q[k][l] >= 0);
        xn  = pos ? x_q[k][l] - dx : x_q[k][l] + dx;
        yn  = pos ? y_q[k][l] + dy : y_q[k][l] - dy;
      end

      if (k < N - 1) begin : g_mid
        always_ff @(posedge clk_i) begin
          if (en) begin
            x_q[k+1][l]    <= xn;
            y_q[k+1][l]    <= yn;
            z_q[k+1][l]    <= pos ? z_q[k][l] - AtanQ24[k] : z_q[k][l] + AtanQ24[k];
            flip_q[k+1][l] <= flip_q[k][l];
          end
        end
      end else begin : g_last
        always_ff @(posedge clk_i) begin
          if (en) begin
            x_q[k+1][l] <= flip_q[k][l] ? -xn : xn;
            y_q[k+1][l] <= flip_q[k][l] ? -yn : yn;
          end
        end
      end
    end
  end

  // Sine and cosine per axis
  logic signed [XyW-1:0] sx, cx, sy, cy, sz, cz;
  assign cx = x_q[N][0];
  assign sx = y_q[N][0];
  assign cy = x_q[N][1];
  assign sy = y_q[N][1];
  assign cz = x_q[N][2];
  assign sz = y_q[N][2];

  // Product stage 1: the pairwise products that the matrix needs
  logic signed [XyW-1:0] sxsy_q, cxsy_q, cycz_q, cysz_q, sxcy_q, cxcy_q;
  logic signed [XyW-1:0] cxsz_q, cxcz_q, sxsz_q, sxcz_q, nsy_q, cz_q, sz_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      sxsy_q <= qmul(sx, sy);
      cxsy_q <= qmul(cx, sy);
      cycz_q <= qmul(cy, cz);
      cysz_q <= qmul(cy, sz);
      sxcy_q <= qmul(sx, cy);
      cxcy_q <= qmul(cx, cy);
      cxsz_q <= qmul(cx, sz);
      cxcz_q <= qmul(cx, cz);
      sxsz_q <= qmul(sx, sz);
      sxcz_q <= qmul(sx, cz);
      nsy_q  <= -sy;
      cz_q   <= cz;
      sz_q   <= sz;
    end
  end

  // Product stage 2: triple products and sums
  logic signed [ZW-1:0] e_q [9];

  always_ff @(posedge clk_i) begin
    if (en) begin
      e_q[0] <= ZW'(cycz_q);
      e_q[1] <= ZW'(cysz_q);
      e_q[2] <= ZW'(nsy_q);
      e_q[3] <= ZW'(qmul(sxsy_q, cz_q)) - ZW'(cxsz_q);
      e_q[4] <= ZW'(cxcz_q) + ZW'(qmul(sxsy_q, sz_q));
      e_q[5] <= ZW'(sxcy_q);
      e_q[6] <= ZW'(sxsz_q) + ZW'(qmul(cxsy_q, cz_q));
      e_q[7] <= ZW'(qmul(cxsy_q, sz_q)) - ZW'(sxcz_q);
      e_q[8] <= ZW'(cxcy_q);
    end
  end

  // Output register: round and saturate
  logic [EntryW-1:0] m_q [9];

  for (genvar j = 0; j < 9; j++) begin : g_out
    always_ff @(posedge clk_i) begin
      if (en) begin
        m_q[j] <= to_out(e_q[j]);
      end
    end
    assign m_axis_tdata[EntryW*j +: EntryW] = m_q[j];
  end

  // Folded CORDIC angles stay within a quarter turn
  a_zrange: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[1] |-> (z_q[0][0] <= ZLimit && z_q[0][0] >= -ZLimit &&
                  z_q[0][1] <= ZLimit && z_q[0][1] >= -ZLimit &&
                  z_q[0][2] <= ZLimit && z_q[0][2] >= -ZLimit))
    else $error("folded angle out of range");

  // Reduction remainder estimate is at most one period low
  a_rem: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[0] |-> ({1'b0, u_q[0]} - 26'(est_q[0]) * 26'(Deg360) < 26'd720))
    else $error("reduction estimate off by more than one");

  // A frozen pipeline keeps its valid bits
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable(vld_q))
    else $error("valid bits moved during stall");

  // Stage valid enters only through an accepted request
  a_enter: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (en && !s_axis_tvalid) |=> !vld_q[0])
    else $error("stage valid without request");

endmodule

`default_nettype wire

>>> tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for euler_to_rotation_matrix: drives angle triples over
// the input stream, predicts each rotation matrix with a local CORDIC model
// and compares all nine entries of every returned result in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb;

  localparam int AngleFrac = 8;
  localparam int OutFrac   = 14;
  localparam int TrigIters = 16;

  typedef struct packed {
    logic signed [23:0] az;
    logic signed [23:0] ay;
    logic signed [23:0] ax;
  } angles_t;

  typedef logic [143:0] matrix_t;

  logic          clk_i;
  logic          rst_ni;
  logic          s_axis_tvalid;
  logic          s_axis_tready;
  logic [71:0]   s_axis_tdata;   // angle_x, angle_y, angle_z
  logic          m_axis_tvalid;
  logic          m_axis_tready;
  logic [143:0]  m_axis_tdata;   // m00,m01,m02,m10,m11,m12,m20,m21,m22

  matrix_t matrix_q[$];
  int      mismatches;
  int      send_idle_pct;
  int      recv_idle_pct;
  int      recv_hold;

  longint atan_q24[32] = '{
    754974720, 445687602, 235489088, 119537938, 60000934, 30029717,
    15018523, 7509720, 3754917, 1877466, 938734, 469367, 234684, 117342,
    58671, 29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29,
    14, 7, 4, 2, 1, 0
  };

  euler_to_rotation_matrix DUT (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
  );

  always begin
    clk_i = 1'b1; #2;
    clk_i = 1'b0; #2;
  end

  // Floor shift for signed values
  function automatic longint floor_shr(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint mul_q30(longint a, longint b);
    return floor_shr(a * b + (64'sd1 <<< 29), 30);
  endfunction

  // Sine and cosine of a degree angle, both Q30
  task automatic trig_deg(input longint ang, output longint s, output longint c);
    longint period, half, quarter, r, x, y, z, dx, dy;
    bit flip;
    period = 360 <<< AngleFrac;
    half = 180 <<< AngleFrac;
    quarter = 90 <<< AngleFrac;
    r = ang % period;
    flip = 0;
    if (r < 0) r += period;
    if (r >= half) r -= period;
    if (r > quarter) begin
      r -= half;
      flip = 1;
    end else if (r < -quarter) begin
      r += half;
      flip = 1;
    end
    z = r * (64'sd1 <<< (24 - AngleFrac));
    x = 652032874;
    y = 0;
    for (int i = 0; i < TrigIters; i++) begin
      dx = floor_shr(y, i);
      dy = floor_shr(x, i);
      if (z >= 0) begin
        x -= dx; y += dy; z -= atan_q24[i];
      end else begin
        x += dx; y -= dy; z += atan_q24[i];
      end
    end
    if (flip) begin
      x = -x; y = -y;
    end
    s = y;
    c = x;
  endtask

  function automatic logic [15:0] to_entry(longint v);
    longint q, one;
    one = 64'sd1 <<< OutFrac;
    q = floor_shr(v + (64'sd1 <<< (29 - OutFrac)), 30 - OutFrac);
    if (q > one) q = one;
    if (q < -one) q = -one;
    return q[15:0];
  endfunction

  task automatic predict_matrix(input angles_t a, output matrix_t m);
    longint sx, cx, sy, cy, sz, cz, sxsy, cxsy;
    trig_deg(a.ax, sx, cx);
    trig_deg(a.ay, sy, cy);
    trig_deg(a.az, sz, cz);
    sxsy = mul_q30(sx, sy);
    cxsy = mul_q30(cx, sy);
    m[15:0]    = to_entry(mul_q30(cy, cz));
    m[31:16]   = to_entry(mul_q30(cy, sz));
    m[47:32]   = to_entry(-sy);
    m[63:48]   = to_entry(mul_q30(sxsy, cz) - mul_q30(cx, sz));
    m[79:64]   = to_entry(mul_q30(cx, cz) + mul_q30(sxsy, sz));
    m[95:80]   = to_entry(mul_q30(sx, cy));
    m[111:96]  = to_entry(mul_q30(sx, sz) + mul_q30(cxsy, cz));
    m[127:112] = to_entry(mul_q30(cxsy, sz) - mul_q30(sx, cz));
    m[143:128] = to_entry(mul_q30(cx, cy));
  endtask

  // Send one request, idling at random first
  task automatic send_angles(input angles_t a);
    matrix_t m;
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    predict_matrix(a, m);
    matrix_q.push_back(m);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= a;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  task automatic send_xyz(input int x, input int y, input int z);
    angles_t a;
    a.ax = 24'(x); a.ay = 24'(y); a.az = 24'(z);
    send_angles(a);
  endtask

  // Drop the request line and wait for every expected result
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    while (matrix_q.size() != 0) @(posedge clk_i);
  endtask

  function automatic logic [23:0] rand_angle();
    case ($urandom_range(3))
      0: return 24'($urandom);
      1: return 24'(($urandom_range(720) - 360) <<< AngleFrac);
      2: return 24'($urandom_range(1000) - 500);
      default: return 24'(($urandom_range(4) * 90) <<< AngleFrac) + 24'($urandom_range(4) - 2);
    endcase
  endfunction

  // Extremes, quadrant edges and saturating cases
  task automatic test_directed();
    int q;
    q = 90 <<< AngleFrac;
    send_xyz(0, 0, 0);
    send_xyz(-8388608, -8388608, -8388608);
    send_xyz(8388607, 8388607, 8388607);
    send_xyz(q, q, q);
    send_xyz(-q, -q, -q);
    send_xyz(q + 1, -q - 1, q - 1);
    send_xyz(2 * q, -2 * q, 2 * q - 1);
    send_xyz(4 * q, -4 * q, 3 * q);
    send_xyz(45 <<< AngleFrac, 30 <<< AngleFrac, 60 <<< AngleFrac);
    send_xyz(1, -1, 1);
    send_xyz(8388607, -8388608, 0);
    send_xyz(24'h555555, 24'haaaaaa, 24'h0f0f0f);
    send_xyz(24'haaaaaa, 24'h555555, 24'hf0f0f0);
    send_xyz(-2 * q + 1, 2 * q + 1, -3 * q);
    drain_results();
  endtask

  task automatic test_random(input int count);
    angles_t a;
    repeat (count) begin
      a.ax = rand_angle();
      a.ay = rand_angle();
      a.az = rand_angle();
      send_angles(a);
    end
  endtask

  // Hold off the receiver while requests keep coming, then pause to drain
  task automatic test_backpressure();
    recv_hold = 200;
    test_random(60);
    drain_results();
  endtask

  // Receiver: random stalls plus an optional long hold-off
  always @(posedge clk_i) begin
    if (recv_hold > 0) begin
      recv_hold <= recv_hold - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Compare each accepted result with the oldest prediction
  always @(posedge clk_i) begin
    matrix_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (matrix_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", m_axis_tdata);
      end else begin
        want = matrix_q.pop_front();
        for (int k = 0; k < 9; k++) begin
          if (m_axis_tdata[k*16 +: 16] !== want[k*16 +: 16]) begin
            mismatches++;
            if (mismatches <= 10)
              $display("m%0d%0d: expected %0d got %0d", k / 3, k % 3,
                       $signed(want[k*16 +: 16]), $signed(m_axis_tdata[k*16 +: 16]));
          end
        end
      end
    end
  end

  initial begin
    rst_ni = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    m_axis_tready = 1'b0;
    mismatches = 0;
    recv_hold = 0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    send_idle_pct = 37; recv_idle_pct = 48;
    test_random(600);
    send_idle_pct = 48; recv_idle_pct = 37;
    test_random(600);
    send_idle_pct = 0; recv_idle_pct = 0;
    test_backpressure();
    test_random(680);
    drain_results();
    repeat (40) @(posedge clk_i);
    if (mismatches == 0 && matrix_q.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

>>> filelist.f
design/e2rm_pkg.sv
design/euler_to_rotation_matrix.sv
tb/tb.sv
